>>> rtl/core/sipd_pkg.sv
// shared constants, types and helpers for the polynomial distortion block
package sipd_pkg;

	// store geometry
	localparam int POWER_SLOTS = 10;
	localparam int BANK_SIZE   = POWER_SLOTS * POWER_SLOTS;
	localparam int MEM_DEPTH   = 4 * BANK_SIZE;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int PIDX_W      = $clog2(POWER_SLOTS);

	// commands carried in the input tuser
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_FWD   = 2'd1;
	localparam logic [1:0] CMD_INV   = 2'd2;
	localparam logic [1:0] CMD_CHECK = 2'd3;

	// shared float unit operations
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	// binary64 constants
	localparam logic [63:0] FP_ONE    = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] FP_ZERO   = 64'h0000_0000_0000_0000;
	localparam logic [63:0] FP_DEFNAN = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] FP_LIMIT  = 64'h4024_0000_0000_0000;

	// request into the float unit
	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} fpu_req_t;

	// flat store address of coefficient (bank, p, q)
	function automatic logic [ADDR_W-1:0] coef_addr(input logic [1:0] bank,
	                                                input logic [PIDX_W-1:0] p,
	                                                input logic [PIDX_W-1:0] q);
		logic [ADDR_W-1:0] r;
		r = ADDR_W'(bank) * ADDR_W'(BANK_SIZE) + ADDR_W'(p) * ADDR_W'(POWER_SLOTS)
		    + ADDR_W'(q);
		return r;
	endfunction

	// absolute value as a compare-and-negate: nan and negative zero pass unchanged
	function automatic logic [63:0] fp_mag(input logic [63:0] d);
		logic is_nan;
		is_nan = (&d[62:52]) && (|d[51:0]);
		return (d[63] && !is_nan && (|d[62:0])) ? {1'b0, d[62:0]} : d;
	endfunction

	// strictly greater than the check limit, nan never counts
	function automatic logic fp_over_limit(input logic [63:0] s);
		logic is_nan;
		is_nan = (&s[62:52]) && (|s[51:0]);
		return !s[63] && !is_nan && (s[62:0] > FP_LIMIT[62:0]);
	endfunction

	// order clamped to the top power slot, negative orders give zero here
	function automatic logic [PIDX_W-1:0] clamp_order(input logic [4:0] o);
		logic [PIDX_W-1:0] r;
		if (o[4])
			r = '0;
		else if (int'(o) > POWER_SLOTS - 1)
			r = PIDX_W'(POWER_SLOTS - 1);
		else
			r = PIDX_W'(o);
		return r;
	endfunction

endpackage

>>> rtl/core/sipd_fpu.sv
// shared iterative binary64 add, subtract and multiply unit
module sipd_fpu import sipd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fpu_req_t    req,
	input  logic [63:0] opa,
	input  logic [63:0] opb,
	output logic        done,
	output logic [63:0] result
);

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_MUL   = 3'd1;
	localparam logic [2:0] F_ALIGN = 3'd2;
	localparam logic [2:0] F_NORM  = 3'd3;
	localparam logic [2:0] F_ROUND = 3'd4;
	localparam logic [2:0] F_DONE  = 3'd5;

	logic [2:0]          st_q;
	logic [2:0]          step_q;
	logic                sgn_q;
	logic                zs_q;
	logic                sub_q;
	logic signed [12:0]  e_q;
	logic [107:0]        m_q;
	logic                stk_q;
	logic [52:0]         ma_q;
	logic [52:0]         mb_q;
	logic [10:0]         d_q;
	logic [53:0]         pp_s1;
	logic [1:0]          psh_q;
	logic [63:0]         res_q;

	// operand decode
	logic [10:0] a_ex, b_ex, a_e1, b_e1, e_diff;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic        b_sg, mul_sg, a_ge_b, is_mul;
	logic [52:0] a_man, b_man;
	logic        spec_hit;
	logic [63:0] spec_val;

	always_comb begin
		a_ex   = opa[62:52];
		b_ex   = opb[62:52];
		a_nan  = (&a_ex) && (|opa[51:0]);
		b_nan  = (&b_ex) && (|opb[51:0]);
		a_inf  = (&a_ex) && !(|opa[51:0]);
		b_inf  = (&b_ex) && !(|opb[51:0]);
		a_zero = !(|opa[62:0]);
		b_zero = !(|opb[62:0]);
		a_man  = {|a_ex, opa[51:0]};
		b_man  = {|b_ex, opb[51:0]};
		a_e1   = (|a_ex) ? a_ex : 11'd1;
		b_e1   = (|b_ex) ? b_ex : 11'd1;
		is_mul = (req.op == OP_MUL);
		b_sg   = opb[63] ^ (req.op == OP_SUB);
		mul_sg = opa[63] ^ opb[63];
		a_ge_b = (opa[62:0] >= opb[62:0]);
		e_diff = a_ge_b ? (a_e1 - b_e1) : (b_e1 - a_e1);
	end

	// nan and infinity operands, and zero operands of a multiply, that bypass the datapath
	always_comb begin
		spec_hit = 1'b1;
		spec_val = FP_DEFNAN;
		if (a_nan) begin
			spec_val = {opa[63:52], 1'b1, opa[50:0]};
		end else if (b_nan) begin
			spec_val = {opb[63:52], 1'b1, opb[50:0]};
		end else if (is_mul) begin
			if ((a_inf && b_zero) || (b_inf && a_zero))
				spec_val = FP_DEFNAN;
			else if (a_inf || b_inf)
				spec_val = {mul_sg, 11'h7FF, 52'd0};
			else if (a_zero || b_zero)
				spec_val = {mul_sg, 63'd0};
			else
				spec_hit = 1'b0;
		end else begin
			if (a_inf && b_inf && (opa[63] != b_sg))
				spec_val = FP_DEFNAN;
			else if (a_inf)
				spec_val = opa;
			else if (b_inf)
				spec_val = {b_sg, 11'h7FF, 52'd0};
			else
				spec_hit = 1'b0;
		end
	end

	// partial product select: low or high halves of the significands
	logic [26:0]  mul_x, mul_y;
	logic [53:0]  mul_p;
	logic [6:0]   pp_sh;
	logic [107:0] pp_acc;

	always_comb begin
		mul_x  = step_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		mul_y  = step_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		mul_p  = mul_x * mul_y;
		case (psh_q)
			2'd0:    pp_sh = 7'd0;
			2'd3:    pp_sh = 7'd54;
			default: pp_sh = 7'd27;
		endcase
		pp_acc = m_q + (108'(pp_s1) << pp_sh);
	end

	// alignment of the smaller operand with sticky in the lowest bit
	logic [107:0] big_x, sml_x, sml_sh, sml_st, al_sum;
	logic         al_lost;

	always_comb begin
		big_x = {2'b00, ma_q, 53'd0};
		sml_x = {2'b00, mb_q, 53'd0};
		if (d_q >= 11'd108) begin
			sml_sh  = '0;
			al_lost = |sml_x;
		end else begin
			sml_sh  = sml_x >> d_q[6:0];
			al_lost = ((sml_sh << d_q[6:0]) != sml_x);
		end
		sml_st = {sml_sh[107:1], sml_sh[0] | al_lost};
		al_sum = sub_q ? (big_x - sml_st) : (big_x + sml_st);
	end

	// denormalizing right shift when the exponent is below one
	logic signed [12:0] dn_diff;
	logic [6:0]         dn_amt;
	logic [107:0]       dn_m;
	logic               dn_lost;

	always_comb begin
		dn_diff = 13'sd1 - e_q;
		dn_amt  = (dn_diff > 13'sd108) ? 7'd108 : dn_diff[6:0];
		dn_m    = m_q >> dn_amt;
		dn_lost = ((dn_m << dn_amt) != m_q);
	end

	// round to nearest even and pack
	logic [52:0]        rk;
	logic               rg, rs, rinc;
	logic [53:0]        rsum;
	logic signed [12:0] rexp;
	logic [63:0]        rval;

	always_comb begin
		rk   = m_q[105:53];
		rg   = m_q[52];
		rs   = (|m_q[51:0]) | stk_q;
		rinc = rg & (rs | rk[0]);
		rsum = {1'b0, rk} + 54'(rinc);
		rexp = e_q + 13'(rsum[53]);
		if (rexp >= 13'sd2047)
			rval = {sgn_q, 11'h7FF, 52'd0};
		else
			rval = {sgn_q, (rsum[53] | rsum[52]) ? rexp[10:0] : 11'd0,
			        rsum[53] ? 52'd0 : rsum[51:0]};
	end

	// sequencing of the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			step_q <= '0;
		end else begin
			case (st_q)
				F_IDLE: begin
					step_q <= '0;
					if (req.start) begin
						if (spec_hit)
							st_q <= F_DONE;
						else if (is_mul)
							st_q <= F_MUL;
						else
							st_q <= F_ALIGN;
					end
				end
				F_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4)
						st_q <= F_NORM;
				end
				F_ALIGN: st_q <= F_NORM;
				F_NORM: begin
					if (m_q[107:106] == 2'b00 && e_q >= 13'sd1 &&
					    !(m_q != '0 && !m_q[105] && e_q > 13'sd1))
						st_q <= F_ROUND;
				end
				F_ROUND: st_q <= F_DONE;
				F_DONE:  st_q <= F_IDLE;
				default: st_q <= F_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				if (req.start) begin
					res_q <= spec_val;
					stk_q <= 1'b0;
					m_q   <= '0;
					if (is_mul) begin
						ma_q  <= a_man;
						mb_q  <= b_man;
						sgn_q <= mul_sg;
						e_q   <= $signed({2'b00, a_e1}) + $signed({2'b00, b_e1}) - 13'sd1022;
					end else begin
						ma_q  <= a_ge_b ? a_man : b_man;
						mb_q  <= a_ge_b ? b_man : a_man;
						e_q   <= $signed({2'b00, a_ge_b ? a_e1 : b_e1});
						d_q   <= e_diff;
						sgn_q <= a_ge_b ? opa[63] : b_sg;
						sub_q <= opa[63] ^ b_sg;
						zs_q  <= opa[63] & b_sg;
					end
				end
			end
			F_MUL: begin
				if (step_q != 3'd4) begin
					pp_s1 <= mul_p;
					psh_q <= step_q[1:0];
				end
				if (step_q != 3'd0)
					m_q <= pp_acc;
			end
			F_ALIGN: begin
				m_q <= al_sum;
				if (al_sum == '0)
					sgn_q <= zs_q;
			end
			F_NORM: begin
				if (m_q[107:106] != 2'b00) begin
					m_q   <= {1'b0, m_q[107:1]};
					stk_q <= stk_q | m_q[0];
					e_q   <= e_q + 13'sd1;
				end else if (e_q < 13'sd1) begin
					m_q   <= dn_m;
					stk_q <= stk_q | dn_lost;
					e_q   <= 13'sd1;
				end else if (m_q != '0 && !m_q[105] && e_q > 13'sd1) begin
					m_q <= {m_q[106:0], 1'b0};
					e_q <= e_q - 13'sd1;
				end
			end
			F_ROUND: res_q <= rval;
			default: ;
		endcase
	end

	assign done   = (st_q == F_DONE);
	assign result = res_q;

endmodule

>>> rtl/core/sipd_coef_ram.sv
// coefficient store: one write port, one registered read port
module sipd_coef_ram import sipd_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [63:0]       wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [63:0]       rdata
);

	logic [63:0] mem [MEM_DEPTH];
	logic [63:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/sip_polynomial_distortion.sv
// top level: sequencer for polynomial distortion over one shared float unit
//
// channel   signals                          carries
// s_axis    tvalid tready tdata[207:0] tuser  command and point or coefficient
// m_axis    tvalid tready tdata[127:0] tuser  transformed point and check flag
// cfg       cfg_we cfg_index cfg_data         reference pixel and orders
//
// a coefficient write gives no item on m_axis
// a transform runs every add and multiply through one float unit (an add after cancellation
// normalizes a bit a cycle); with n terms per polynomial one pass costs about 6*n ops,
// a check runs two passes
// after reset all 400 store entries are cleared while s_axis tready stays low
// s_axis tready is high only between items; a finished item waits in the m_axis register
module sip_polynomial_distortion import sipd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// coord_x, coord_y, coef_bank, power_u, power_v, coef_value, zero fill
	input  logic [207:0] s_axis_tdata,
	// command
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x, out_y
	output logic [127:0] m_axis_tdata,
	// check_failed
	output logic         m_axis_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam logic [2:0] REG_REF_X = 3'd0;
	localparam logic [2:0] REG_REF_Y = 3'd1;
	localparam logic [2:0] REG_FWD_X = 3'd2;
	localparam logic [2:0] REG_FWD_Y = 3'd3;
	localparam logic [2:0] REG_INV_X = 3'd4;
	localparam logic [2:0] REG_INV_Y = 3'd5;

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_SUBX   = 5'd2;
	localparam logic [4:0] S_SUBY   = 5'd3;
	localparam logic [4:0] S_PINIT  = 5'd4;
	localparam logic [4:0] S_POW    = 5'd5;
	localparam logic [4:0] S_SINIT  = 5'd6;
	localparam logic [4:0] S_SSTART = 5'd7;
	localparam logic [4:0] S_RD     = 5'd8;
	localparam logic [4:0] S_M1     = 5'd9;
	localparam logic [4:0] S_M2     = 5'd10;
	localparam logic [4:0] S_ACC    = 5'd11;
	localparam logic [4:0] S_RX     = 5'd12;
	localparam logic [4:0] S_RY     = 5'd13;
	localparam logic [4:0] S_PEND   = 5'd14;
	localparam logic [4:0] S_D1     = 5'd15;
	localparam logic [4:0] S_D2     = 5'd16;
	localparam logic [4:0] S_DS     = 5'd17;
	localparam logic [4:0] S_OX     = 5'd18;
	localparam logic [4:0] S_OY     = 5'd19;
	localparam logic [4:0] S_FIN    = 5'd20;

	// input item fields
	logic [63:0] coord_x, coord_y, coef_value;
	logic [1:0]  coef_bank, command;
	logic [3:0]  power_u, power_v;

	assign coord_x    = s_axis_tdata[63:0];
	assign coord_y    = s_axis_tdata[127:64];
	assign coef_bank  = s_axis_tdata[129:128];
	assign power_u    = s_axis_tdata[133:130];
	assign power_v    = s_axis_tdata[137:134];
	assign coef_value = s_axis_tdata[201:138];
	assign command    = s_axis_tuser;

	// configuration registers
	logic [63:0] ref_x_q, ref_y_q;
	logic [4:0]  fwd_x_ord_q, fwd_y_ord_q, inv_x_ord_q, inv_y_ord_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q     <= '0;
			ref_y_q     <= '0;
			fwd_x_ord_q <= '0;
			fwd_y_ord_q <= '0;
			inv_x_ord_q <= '0;
			inv_y_ord_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REF_X: ref_x_q     <= cfg_data;
				REG_REF_Y: ref_y_q     <= cfg_data;
				REG_FWD_X: fwd_x_ord_q <= cfg_data[4:0];
				REG_FWD_Y: fwd_y_ord_q <= cfg_data[4:0];
				REG_INV_X: inv_x_ord_q <= cfg_data[4:0];
				REG_INV_Y: inv_y_ord_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// sequencer state
	logic [4:0]        state_q;
	logic              issued_q;
	logic [ADDR_W-1:0] clr_q;
	logic [1:0]        cmd_q;
	logic              pass_q;
	logic              ax_q;
	logic              axis_q;
	logic [PIDX_W:0]   k_q;
	logic [PIDX_W-1:0] p_q, q_q;
	logic              fail_q;
	logic              out_valid_q;

	// working values
	logic [63:0] x_q, y_q, u_q, v_q, ru_q, rv_q, fs_q, gs_q, t_q, lpu_q, lpv_q;
	logic [63:0] pu_q [POWER_SLOTS];
	logic [63:0] pv_q [POWER_SLOTS];
	logic [63:0] out_x_q, out_y_q;
	logic        out_fail_q;

	// pass selection: first pass of inverse and check commands uses the inverse banks
	logic              use_inv;
	logic [4:0]        ord_x, ord_y;
	logic [PIDX_W-1:0] ox_c, oy_c, top_c, cur_ord;
	logic              cur_neg;
	logic [63:0]       pin_u, pin_v;
	logic [PIDX_W:0]   pq_sum;

	always_comb begin
		use_inv = !pass_q && (cmd_q != CMD_FWD);
		ord_x   = use_inv ? inv_x_ord_q : fwd_x_ord_q;
		ord_y   = use_inv ? inv_y_ord_q : fwd_y_ord_q;
		ox_c    = clamp_order(ord_x);
		oy_c    = clamp_order(ord_y);
		top_c   = (ox_c > oy_c) ? ox_c : oy_c;
		cur_ord = ax_q ? oy_c : ox_c;
		cur_neg = ax_q ? ord_y[4] : ord_x[4];
		pin_u   = pass_q ? ru_q : u_q;
		pin_v   = pass_q ? rv_q : v_q;
		pq_sum  = {1'b0, p_q} + {1'b0, q_q};
	end

	// coefficient store
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [63:0]       mem_wdata, mem_rdata;
	logic              in_acc;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = FP_ZERO;
		if (state_q == S_CLR) begin
			mem_we = 1'b1;
		end else if (in_acc && command == CMD_WRITE &&
		             int'(power_u) < POWER_SLOTS && int'(power_v) < POWER_SLOTS) begin
			mem_we    = 1'b1;
			mem_waddr = coef_addr(coef_bank, power_u[PIDX_W-1:0], power_v[PIDX_W-1:0]);
			mem_wdata = coef_value;
		end
		mem_raddr = coef_addr({use_inv, ax_q}, p_q, q_q);
	end

	sipd_coef_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// float unit operand selection
	fpu_req_t    fpu_req;
	logic [63:0] fpu_a, fpu_b, fpu_res;
	logic        fpu_done;
	logic        op_state;

	always_comb begin
		op_state = state_q inside {S_SUBX, S_SUBY, S_POW, S_M1, S_M2, S_ACC, S_RX,
		                           S_RY, S_D1, S_D2, S_DS, S_OX, S_OY};
		fpu_req.start = op_state && !issued_q;
		fpu_req.op    = OP_ADD;
		fpu_a         = fs_q;
		fpu_b         = gs_q;
		case (state_q)
			S_SUBX: begin fpu_req.op = OP_SUB; fpu_a = x_q; fpu_b = ref_x_q; end
			S_SUBY: begin fpu_req.op = OP_SUB; fpu_a = y_q; fpu_b = ref_y_q; end
			S_POW: begin
				fpu_req.op = OP_MUL;
				fpu_a      = axis_q ? lpv_q : lpu_q;
				fpu_b      = axis_q ? pin_v : pin_u;
			end
			S_M1:  begin fpu_req.op = OP_MUL; fpu_a = mem_rdata; fpu_b = pu_q[p_q]; end
			S_M2:  begin fpu_req.op = OP_MUL; fpu_a = t_q; fpu_b = pv_q[q_q]; end
			S_ACC: begin fpu_a = ax_q ? gs_q : fs_q; fpu_b = t_q; end
			S_RX:  begin fpu_a = pin_u; fpu_b = fs_q; end
			S_RY:  begin fpu_a = pin_v; fpu_b = gs_q; end
			S_D1:  begin fpu_req.op = OP_SUB; fpu_a = fs_q; fpu_b = u_q; end
			S_D2:  begin fpu_req.op = OP_SUB; fpu_a = gs_q; fpu_b = v_q; end
			S_DS:  begin fpu_a = fs_q; fpu_b = gs_q; end
			S_OX:  begin fpu_a = ru_q; fpu_b = ref_x_q; end
			S_OY:  begin fpu_a = rv_q; fpu_b = ref_y_q; end
			default: ;
		endcase
	end

	sipd_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.opa    (fpu_a),
		.opb    (fpu_b),
		.done   (fpu_done),
		.result (fpu_res)
	);

	logic out_free;
	assign out_free = !out_valid_q || m_axis_tready;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			issued_q    <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			pass_q      <= 1'b0;
			ax_q        <= 1'b0;
			axis_q      <= 1'b0;
			k_q         <= '0;
			p_q         <= '0;
			q_q         <= '0;
			cmd_q       <= CMD_WRITE;
		end else begin
			if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (fpu_req.start)
				issued_q <= 1'b1;
			if (fpu_done)
				issued_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (int'(clr_q) == MEM_DEPTH - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc && command != CMD_WRITE) begin
						cmd_q  <= command;
						pass_q <= 1'b0;
						state_q <= fwd_x_ord_q[4] ? S_FIN : S_SUBX;
					end
				end
				S_SUBX: if (fpu_done) state_q <= S_SUBY;
				S_SUBY: if (fpu_done) state_q <= S_PINIT;
				S_PINIT: begin
					k_q     <= (PIDX_W+1)'(2);
					axis_q  <= 1'b0;
					state_q <= (int'(top_c) >= 2) ? S_POW : S_SINIT;
				end
				S_POW: begin
					if (fpu_done) begin
						axis_q <= !axis_q;
						if (axis_q) begin
							k_q <= k_q + (PIDX_W+1)'(1);
							if (k_q[PIDX_W-1:0] == top_c)
								state_q <= S_SINIT;
						end
					end
				end
				S_SINIT: begin
					ax_q    <= 1'b0;
					state_q <= S_SSTART;
				end
				S_SSTART: begin
					p_q <= '0;
					q_q <= '0;
					if (!cur_neg)
						state_q <= S_RD;
					else if (!ax_q)
						ax_q <= 1'b1;
					else
						state_q <= S_RX;
				end
				S_RD: state_q <= S_M1;
				S_M1: if (fpu_done) state_q <= S_M2;
				S_M2: if (fpu_done) state_q <= S_ACC;
				S_ACC: begin
					if (fpu_done) begin
						if (pq_sum < {1'b0, cur_ord}) begin
							q_q     <= q_q + PIDX_W'(1);
							state_q <= S_RD;
						end else if (p_q < cur_ord) begin
							p_q     <= p_q + PIDX_W'(1);
							q_q     <= '0;
							state_q <= S_RD;
						end else if (!ax_q) begin
							ax_q    <= 1'b1;
							state_q <= S_SSTART;
						end else begin
							state_q <= S_RX;
						end
					end
				end
				S_RX: if (fpu_done) state_q <= S_RY;
				S_RY: if (fpu_done) state_q <= S_PEND;
				S_PEND: begin
					if (cmd_q == CMD_CHECK && !pass_q) begin
						pass_q  <= 1'b1;
						state_q <= S_PINIT;
					end else if (cmd_q == CMD_CHECK) begin
						state_q <= S_D1;
					end else begin
						state_q <= S_OX;
					end
				end
				S_D1: if (fpu_done) state_q <= S_D2;
				S_D2: if (fpu_done) state_q <= S_DS;
				S_DS: if (fpu_done) state_q <= fp_over_limit(fpu_res) ? S_FIN : S_OX;
				S_OX: if (fpu_done) state_q <= S_OY;
				S_OY: if (fpu_done) state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working value registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q    <= coord_x;
				y_q    <= coord_y;
				fs_q   <= coord_x;
				gs_q   <= coord_y;
				fail_q <= 1'b0;
			end
			S_SUBX: if (fpu_done) u_q <= fpu_res;
			S_SUBY: if (fpu_done) v_q <= fpu_res;
			S_PINIT: begin
				pu_q[0] <= FP_ONE;
				pv_q[0] <= FP_ONE;
				pu_q[1] <= pin_u;
				pv_q[1] <= pin_v;
				lpu_q   <= pin_u;
				lpv_q   <= pin_v;
			end
			S_POW: begin
				if (fpu_done) begin
					if (axis_q) begin
						pv_q[k_q[PIDX_W-1:0]] <= fpu_res;
						lpv_q <= fpu_res;
					end else begin
						pu_q[k_q[PIDX_W-1:0]] <= fpu_res;
						lpu_q <= fpu_res;
					end
				end
			end
			S_SINIT: begin
				fs_q <= FP_ZERO;
				gs_q <= FP_ZERO;
			end
			S_M1, S_M2: if (fpu_done) t_q <= fpu_res;
			S_ACC: begin
				if (fpu_done) begin
					if (ax_q)
						gs_q <= fpu_res;
					else
						fs_q <= fpu_res;
				end
			end
			S_RX: if (fpu_done) fs_q <= fpu_res;
			S_RY: if (fpu_done) gs_q <= fpu_res;
			S_PEND: begin
				if (!pass_q) begin
					ru_q <= fs_q;
					rv_q <= gs_q;
				end
			end
			S_D1: if (fpu_done) fs_q <= fp_mag(fpu_res);
			S_D2: if (fpu_done) gs_q <= fp_mag(fpu_res);
			S_DS: begin
				if (fpu_done && fp_over_limit(fpu_res)) begin
					fs_q   <= x_q;
					gs_q   <= y_q;
					fail_q <= 1'b1;
				end
			end
			S_OX: if (fpu_done) fs_q <= fpu_res;
			S_OY: if (fpu_done) gs_q <= fpu_res;
			S_FIN: begin
				if (out_free) begin
					out_x_q    <= fs_q;
					out_y_q    <= gs_q;
					out_fail_q <= fail_q;
				end
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_y_q, out_x_q};
	assign m_axis_tuser  = out_fail_q;

endmodule
